FILE: rtl/wall_bitmap_autotiler_macros.svh
// Assertion macros shared by the autotiler RTL.
`ifndef WALL_BITMAP_AUTOTILER_MACROS_SVH
`define WALL_BITMAP_AUTOTILER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WBAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbat: implication check failed");

// Implication with the consequent checked later than the antecedent.
`define WBAT_ASSERT_D2(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("wbat: two-cycle check failed");

`endif

FILE: rtl/wbat_pkg.sv
// Shared types and constants of the wall bitmap autotiler.
package wbat_pkg;

  localparam int DEF_MAP_COLUMNS = 32;
  localparam int DEF_MAP_ROWS    = 24;

  // Width for byte address arithmetic; covers any row/column the ports can name.
  localparam int CALC_W = 11;

  localparam logic [3:0] MASK_LEFT   = 4'h1;
  localparam logic [3:0] MASK_RIGHT  = 4'h2;
  localparam logic [3:0] MASK_TOP    = 4'h4;
  localparam logic [3:0] MASK_BOTTOM = 4'h8;
  localparam logic [3:0] MASK_ALL    = 4'hf;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Per-query info carried from the address stage to the tile stage.
  typedef struct packed {
    logic       bad;        // cell outside the map
    logic       last_col;   // last column, fixed code
    logic       first_col;  // left side is the map border
    logic       right_ok;   // right neighbor is a cell before the last column
    logic       top_edge;   // first row
    logic       bot_edge;   // last row
    logic [2:0] bit_sel;    // bit of the cell inside its byte
  } query_t;

endpackage

FILE: rtl/wall_bitmap_autotiler.sv
// Top level of the wall bitmap autotiler.
//
// Usage:
//   Commands enter on start/opcode_i; a command transfers at a clock edge with
//   start high and busy low. busy is always low: a command can be issued every
//   cycle. opcode_i = write stores map_byte_i at byte_index_i (rows are
//   1 + MAP_COLUMNS/8 bytes, cell x is bit x+1 of its row); writes beyond the
//   map are dropped and never give a result. opcode_i = query looks up the
//   cell at cell_column_i/cell_row_i.
//   A query's result shows on tile_code_o/bad_cell_o with done_o high
//   for exactly one cycle, after the map store read and lookup registers,
//   then the tile result register. Throughput is one command per cycle.
//   A write followed by a query in the next cycle already sees the new byte.
//   Results cannot be held off; the receiver must take them on done_o.
//   tile_base is written with cfg_we_i/cfg_wdata_i; the user must do so only
//   while no query is in flight, the block does not enforce it. Reset clears
//   tile_base and the pipeline valids; map bytes are undefined until written
//   and must be loaded before the cells that read them are queried.
`include "wall_bitmap_autotiler_macros.svh"

module wall_bitmap_autotiler #(
  parameter int MAP_COLUMNS = wbat_pkg::DEF_MAP_COLUMNS,
  parameter int MAP_ROWS    = wbat_pkg::DEF_MAP_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       opcode_i,
  input  logic [6:0] byte_index_i,
  input  logic [7:0] map_byte_i,
  input  logic [4:0] cell_column_i,
  input  logic [4:0] cell_row_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic [7:0] tile_code_o,
  output logic       bad_cell_o,
  output logic       done_o
);

  import wbat_pkg::*;

  localparam int STRIDE    = 1 + MAP_COLUMNS / 8;
  localparam int MAP_BYTES = MAP_ROWS * STRIDE;
  localparam int ADDR_W    = $clog2(MAP_BYTES);

  logic              cmd_xfer;
  logic              query_xfer;
  logic              write_en;
  logic [7:0]        tile_base_q;
  logic [ADDR_W-1:0] center_addr;
  logic [ADDR_W-1:0] side_addr;
  logic [ADDR_W-1:0] up_addr;
  logic [ADDR_W-1:0] down_addr;
  logic [7:0]        center_byte;
  logic [7:0]        side_byte;
  logic [7:0]        up_byte;
  logic [7:0]        down_byte;
  logic              query_valid;
  query_t            query;

  assign busy       = 1'b0;
  assign cmd_xfer   = start && !busy;
  assign query_xfer = cmd_xfer && (opcode_i == OP_QUERY);
  // Writes past the end of the map are dropped.
  assign write_en   = cmd_xfer && (opcode_i == OP_WRITE) &&
                      (int'(byte_index_i) < MAP_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_base_q <= '0;
    end else if (cfg_we_i) begin
      tile_base_q <= cfg_wdata_i;
    end
  end

  wbat_lookup #(
    .MAP_COLUMNS (MAP_COLUMNS),
    .MAP_ROWS    (MAP_ROWS),
    .ADDR_W      (ADDR_W)
  ) u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_i       (query_xfer),
    .cell_column_i (cell_column_i),
    .cell_row_i    (cell_row_i),
    .center_addr_o (center_addr),
    .side_addr_o   (side_addr),
    .up_addr_o     (up_addr),
    .down_addr_o   (down_addr),
    .query_valid_o (query_valid),
    .query_o       (query)
  );

  // Two copies of the map, written together, give four reads per cycle:
  // the cell's row (cell byte and the byte across a byte edge), above, below.
  wbat_mem #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem_row (
    .clk_i     (clk_i),
    .we_i      (write_en),
    .waddr_i   (ADDR_W'(byte_index_i)),
    .wdata_i   (map_byte_i),
    .raddr_a_i (center_addr),
    .raddr_b_i (side_addr),
    .rdata_a_o (center_byte),
    .rdata_b_o (side_byte)
  );

  wbat_mem #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem_vert (
    .clk_i     (clk_i),
    .we_i      (write_en),
    .waddr_i   (ADDR_W'(byte_index_i)),
    .wdata_i   (map_byte_i),
    .raddr_a_i (up_addr),
    .raddr_b_i (down_addr),
    .rdata_a_o (up_byte),
    .rdata_b_o (down_byte)
  );

  wbat_tile u_tile (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_valid_i (query_valid),
    .query_i       (query),
    .center_byte_i (center_byte),
    .side_byte_i   (side_byte),
    .up_byte_i     (up_byte),
    .down_byte_i   (down_byte),
    .tile_base_i   (tile_base_q),
    .tile_code_o   (tile_code_o),
    .bad_cell_o    (bad_cell_o),
    .done_o        (done_o)
  );

  // A result only ever follows an earlier query transfer.
  `WBAT_ASSERT_IMP(a_done_from_query, clk_i, rst_ni, done_o, $past(query_xfer, 2))
  // A write transfer never produces a result.
  `WBAT_ASSERT_D2(a_write_silent, clk_i, rst_ni, cmd_xfer && (opcode_i == OP_WRITE), !done_o)
  // A bad cell always reports code zero.
  `WBAT_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, done_o && bad_cell_o, tile_code_o == 8'd0)

endmodule

FILE: rtl/wbat_mem.sv
// Map byte store: one write port, two registered read ports.
module wbat_mem #(
  parameter int DEPTH  = 120,
  parameter int ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [7:0]        rdata_a_o,
  output logic [7:0]        rdata_b_o
);

  logic [7:0] store_q [DEPTH];
  logic [7:0] rd_a_q;
  logic [7:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= store_q[raddr_a_i];
    rd_b_q <= store_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

FILE: rtl/wbat_lookup.sv
// Address stage: byte addresses of a cell and its neighbors, query info register.
module wbat_lookup #(
  parameter int MAP_COLUMNS = 32,
  parameter int MAP_ROWS    = 24,
  parameter int ADDR_W      = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                query_i,
  input  logic [4:0]          cell_column_i,
  input  logic [4:0]          cell_row_i,
  output logic [ADDR_W-1:0]   center_addr_o,
  output logic [ADDR_W-1:0]   side_addr_o,
  output logic [ADDR_W-1:0]   up_addr_o,
  output logic [ADDR_W-1:0]   down_addr_o,
  output logic                query_valid_o,
  output wbat_pkg::query_t    query_o
);

  import wbat_pkg::*;

  localparam int STRIDE    = 1 + MAP_COLUMNS / 8;
  localparam int MAP_BYTES = MAP_ROWS * STRIDE;

  logic [5:0]        pos;
  logic [CALC_W-1:0] row_base;
  logic [CALC_W-1:0] center;
  logic [CALC_W-1:0] side;
  logic [CALC_W-1:0] up;
  logic [CALC_W-1:0] down;
  query_t            query_d;
  query_t            query_q;
  logic              valid_q;

  // Out-of-range addresses belong to neighbors that are never looked at.
  function automatic logic [ADDR_W-1:0] clamp(input logic [CALC_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = '0;
    if (a < CALC_W'(MAP_BYTES)) begin
      r = ADDR_W'(a);
    end
    return r;
  endfunction

  always_comb begin
    pos      = 6'(cell_column_i) + 6'd1;
    row_base = CALC_W'(cell_row_i) * CALC_W'(STRIDE);
    center   = row_base + CALC_W'(pos[5:3]);
    // Horizontal neighbor crosses a byte only at the byte edges.
    side     = (pos[2:0] == 3'd0) ? center - CALC_W'(1) : center + CALC_W'(1);
    up       = (cell_row_i == 5'd0) ? '0 : center - CALC_W'(STRIDE);
    down     = center + CALC_W'(STRIDE);

    query_d.bad       = (int'(cell_column_i) >= MAP_COLUMNS) ||
                        (int'(cell_row_i) >= MAP_ROWS);
    query_d.last_col  = int'(cell_column_i) == MAP_COLUMNS - 1;
    query_d.first_col = cell_column_i == 5'd0;
    query_d.right_ok  = int'(cell_column_i) < MAP_COLUMNS - 2;
    query_d.top_edge  = cell_row_i == 5'd0;
    query_d.bot_edge  = int'(cell_row_i) == MAP_ROWS - 1;
    query_d.bit_sel   = pos[2:0];
  end

  assign center_addr_o = clamp(center);
  assign side_addr_o   = clamp(side);
  assign up_addr_o     = clamp(up);
  assign down_addr_o   = clamp(down);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= query_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_i) begin
      query_q <= query_d;
    end
  end

  assign query_valid_o = valid_q;
  assign query_o       = query_q;

endmodule

FILE: rtl/wbat_tile.sv
// Tile stage: edge mask from the fetched bytes, registered result.
module wbat_tile (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             query_valid_i,
  input  wbat_pkg::query_t query_i,
  input  logic [7:0]       center_byte_i,
  input  logic [7:0]       side_byte_i,
  input  logic [7:0]       up_byte_i,
  input  logic [7:0]       down_byte_i,
  input  logic [7:0]       tile_base_i,
  output logic [7:0]       tile_code_o,
  output logic             bad_cell_o,
  output logic             done_o
);

  import wbat_pkg::*;

  logic       wall;
  logic       left_wall;
  logic       right_wall;
  logic [3:0] mask;
  logic [7:0] code_d;
  logic [7:0] code_q;
  logic       bad_q;
  logic       done_q;

  always_comb begin
    wall       = center_byte_i[query_i.bit_sel];
    left_wall  = (query_i.bit_sel == 3'd0) ? side_byte_i[7]
                                          : center_byte_i[query_i.bit_sel - 3'd1];
    right_wall = (query_i.bit_sel == 3'd7) ? side_byte_i[0]
                                          : center_byte_i[query_i.bit_sel + 3'd1];

    mask = '0;
    if (!query_i.first_col && !left_wall) mask = mask | MASK_LEFT;
    if (query_i.right_ok && !right_wall) mask = mask | MASK_RIGHT;
    if (query_i.top_edge || !up_byte_i[query_i.bit_sel]) mask = mask | MASK_TOP;
    if (query_i.bot_edge || !down_byte_i[query_i.bit_sel]) mask = mask | MASK_BOTTOM;

    if (query_i.bad) begin
      code_d = '0;
    end else if (query_i.last_col) begin
      code_d = tile_base_i + 8'(MASK_ALL);
    end else if (!wall) begin
      code_d = tile_base_i;
    end else begin
      code_d = tile_base_i + 8'(mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= query_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_valid_i) begin
      code_q <= code_d;
      bad_q  <= query_i.bad;
    end
  end

  assign tile_code_o = code_q;
  assign bad_cell_o  = bad_q;
  assign done_o      = done_q;

endmodule

FILE: bench/wbat_tile_checker.sv
`timescale 1ns / 1ps
// Transfer monitor, tile code predictor and result comparison for the autotiler.
module wbat_tile_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  logic       opcode_i,
  input  logic [6:0] byte_index_i,
  input  logic [7:0] map_byte_i,
  input  logic [4:0] cell_column_i,
  input  logic [4:0] cell_row_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [7:0] tile_code_o,
  input  logic       bad_cell_o,
  input  logic       done_o,
  output int         fail_count_o,
  output int         pending_o
);

  import wbat_pkg::*;

  localparam int MAP_COLUMNS = DEF_MAP_COLUMNS;
  localparam int MAP_ROWS    = DEF_MAP_ROWS;
  localparam int MAP_STRIDE  = 1 + MAP_COLUMNS / 8;
  localparam int MAP_BYTES   = MAP_ROWS * MAP_STRIDE;

  typedef struct packed {
    logic [7:0] code;
    logic       bad;
    logic [4:0] col;  // for reports only
    logic [4:0] row;
  } tile_t;

  logic [7:0] wall_map_copy [MAP_BYTES];
  logic [7:0] tile_base_copy = '0;
  tile_t      expected_tiles [$];
  int         mismatch_count = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    foreach (wall_map_copy[i]) wall_map_copy[i] = '0;
  end

  // Wall bit of cell (x, y); cell x sits at bit x+1 of its row.
  function automatic logic wall_at(int x, int y);
    int pos;
    int idx;
    pos = x + 1;
    idx = y * MAP_STRIDE + (pos >> 3);
    if (idx >= MAP_BYTES) return 1'b0;
    return wall_map_copy[idx][pos & 7];
  endfunction

  function automatic tile_t predict_tile(int col, int row);
    tile_t      t;
    logic [3:0] edges;
    t       = '0;
    t.col   = col[4:0];
    t.row   = row[4:0];
    edges   = '0;
    if (col >= MAP_COLUMNS || row >= MAP_ROWS) begin
      t.bad = 1'b1;
      return t;
    end
    if (col == MAP_COLUMNS - 1) begin
      edges = MASK_ALL;
    end else if (wall_at(col, row)) begin
      // left border and the last column count as walls; top/bottom edges as empty
      if (col > 0 && !wall_at(col - 1, row)) edges |= MASK_LEFT;
      if (col < MAP_COLUMNS - 2 && !wall_at(col + 1, row)) edges |= MASK_RIGHT;
      if (row == 0 || !wall_at(col, row - 1)) edges |= MASK_TOP;
      if (row == MAP_ROWS - 1 || !wall_at(col, row + 1)) edges |= MASK_BOTTOM;
    end
    t.code = tile_base_copy + {4'h0, edges};
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tile_t want;
    if (!rst_ni) begin
      tile_base_copy = '0;
      expected_tiles.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) tile_base_copy = cfg_wdata_i;

      // result leaves the block this edge
      if (done_o !== 1'b0) begin
        if (expected_tiles.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no query waiting: expected none, actual code %h bad %b",
                   $time, tile_code_o, bad_cell_o);
        end else begin
          want = expected_tiles.pop_front();
          if (tile_code_o !== want.code || bad_cell_o !== want.bad) begin
            mismatch_count++;
            $display("%0t: cell (%0d,%0d) expected code %h bad %b, actual code %h bad %b",
                     $time, want.col, want.row, want.code, want.bad,
                     tile_code_o, bad_cell_o);
          end
        end
      end

      // command transfer
      if (start && !busy) begin
        if (opcode_i == OP_QUERY) begin
          expected_tiles.push_back(predict_tile(int'(cell_column_i), int'(cell_row_i)));
        end else if (byte_index_i < MAP_BYTES) begin
          wall_map_copy[byte_index_i] = map_byte_i;
        end
      end

      pending_o    <= expected_tiles.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

FILE: bench/wall_bitmap_autotiler_tb.sv
`timescale 1ns / 1ps
// Autotiler bench top: clock, reset, command stimulus, tile base phases and verdict.
module wall_bitmap_autotiler_tb;
  import wbat_pkg::*;

  localparam int MAP_STRIDE   = 1 + DEF_MAP_COLUMNS / 8;  // 5 bytes per row
  localparam int MAP_BYTES    = DEF_MAP_ROWS * MAP_STRIDE;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASES       = 5;
  // Settling wait after the last result, with slack past a query's path.
  localparam int SETTLE       = 4;
  // Slowest run, every command behind the longest idle gap, stays well under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       opcode_i;
  logic [6:0] byte_index_i;
  logic [7:0] map_byte_i;
  logic [4:0] cell_column_i;
  logic [4:0] cell_row_i;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic [7:0] tile_code_o;
  logic       bad_cell_o;
  logic       done_o;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  logic no_gaps = 1'b0;  // set for stretches of back-to-back transfers

  always #4 clk_i = ~clk_i;

  wall_bitmap_autotiler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .byte_index_i (byte_index_i),
    .map_byte_i   (map_byte_i),
    .cell_column_i(cell_column_i),
    .cell_row_i   (cell_row_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tile_code_o  (tile_code_o),
    .bad_cell_o   (bad_cell_o),
    .done_o       (done_o)
  );

  // Watches both sides of the block, predicts and compares.
  wbat_tile_checker u_tile_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .byte_index_i (byte_index_i),
    .map_byte_i   (map_byte_i),
    .cell_column_i(cell_column_i),
    .cell_row_i   (cell_row_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tile_code_o  (tile_code_o),
    .bad_cell_o   (bad_cell_o),
    .done_o       (done_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wall_bitmap_autotiler_tb: FAIL");
      $finish;
    end
  end

  // Wall byte of varying density: plain random, dense (OR) or sparse (AND).
  // Dense bytes make enclosed walls likely, sparse ones give lone walls.
  function automatic logic [7:0] wall_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return 8'($urandom | $urandom);
      2:       return 8'($urandom & $urandom);
      default: return 8'($urandom | $urandom | $urandom);
    endcase
  endfunction

  // One command transfer. Idle gap first (start low), then hold start until
  // the edge where busy is low. Only one NBA per signal per time step: a
  // zero gap keeps start high straight into the next command.
  task automatic issue_command(input logic op, input logic [6:0] idx,
                               input logic [7:0] data, input logic [4:0] col,
                               input logic [4:0] row);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    byte_index_i  <= idx;
    map_byte_i    <= data;
    cell_column_i <= col;
    cell_row_i    <= row;
    do @(posedge clk_i); while (busy);
  endtask

  // Unused fields of each command carry random noise.
  task automatic write_byte(input logic [6:0] idx, input logic [7:0] data);
    issue_command(OP_WRITE, idx, data, 5'($urandom), 5'($urandom));
  endtask

  task automatic query_cell(input logic [4:0] col, input logic [4:0] row);
    issue_command(OP_QUERY, 7'($urandom), 8'($urandom), col, row);
  endtask

  // Wait until every query has produced its result, then SETTLE more edges:
  // a write still in the pipe never shows up on the result side.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_tile_base(input logic [7:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_command();
    logic [4:0] col;
    logic [4:0] row;
    if ($urandom_range(0, 99) < 35) begin
      // about one write in sixteen lands past the map and must be dropped
      if ($urandom_range(0, 15) == 0)
        write_byte(7'($urandom_range(MAP_BYTES, 127)), wall_byte());
      else
        write_byte(7'($urandom_range(0, MAP_BYTES - 1)), wall_byte());
    end else begin
      // lean on the left border, the column before the last and the last one
      case ($urandom_range(0, 9))
        0:       col = 5'd0;
        1:       col = 5'(DEF_MAP_COLUMNS - 2);
        2:       col = 5'(DEF_MAP_COLUMNS - 1);
        default: col = 5'($urandom);
      endcase
      case ($urandom_range(0, 11))
        0:       row = 5'($urandom_range(DEF_MAP_ROWS, 31));  // off the map
        1:       row = 5'd0;
        2:       row = 5'(DEF_MAP_ROWS - 1);
        default: row = 5'($urandom_range(0, DEF_MAP_ROWS - 1));
      endcase
      query_cell(col, row);
    end
  endtask

  initial begin
    logic [7:0] base;
    int         map_row;

    // every input known from time zero; reset held at the start
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    opcode_i      <= OP_WRITE;
    byte_index_i  <= '0;
    map_byte_i    <= '0;
    cell_column_i <= '0;
    cell_row_i    <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Base near the top so that edge masks wrap past 255.
    write_tile_base(8'hF8);

    // Load the whole map before any query: the store is undefined until
    // written. Top row, bottom row and rows 5..7 are solid walls.
    for (int i = 0; i < MAP_BYTES; i++) begin
      map_row = i / MAP_STRIDE;
      if (map_row == 0 || map_row == DEF_MAP_ROWS - 1 || (map_row >= 5 && map_row <= 7))
        write_byte(7'(i), 8'hFF);
      else
        write_byte(7'(i), wall_byte());
    end

    // Directed cases.
    write_byte(7'd120, 8'h00);  // just past the map: dropped
    write_byte(7'd127, 8'hFF);
    query_cell(5'd10, 5'd6);    // enclosed wall: base only
    query_cell(5'd0, 5'd6);     // left border counts as wall
    query_cell(5'd30, 5'd6);    // column before the last: right side is wall
    query_cell(5'd0, 5'd0);     // top edge counts as empty
    query_cell(5'd20, 5'd0);
    query_cell(5'd15, 5'd23);   // bottom edge counts as empty
    query_cell(5'd31, 5'd0);    // last column: base + 15 whatever the bits
    query_cell(5'd31, 5'd23);
    query_cell(5'd31, 5'd10);
    // empty cell, then the same byte turned to walls and queried right after
    write_byte(7'd50, 8'h00);
    query_cell(5'd3, 5'd10);
    write_byte(7'd50, 8'hFE);
    query_cell(5'd3, 5'd10);
    // lone wall with empty cells on all four sides: full mask, wraps
    write_byte(7'd56, 8'h00);
    write_byte(7'd61, 8'h10);
    write_byte(7'd66, 8'h00);
    query_cell(5'd11, 5'd12);
    // off the map
    query_cell(5'd5, 5'd24);
    query_cell(5'd0, 5'd31);
    query_cell(5'd31, 5'd24);
    query_cell(5'd31, 5'd31);

    // Random phases, each with its own tile base, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       base = 8'h00;
        1:       base = 8'hFF;
        2:       base = 8'hF1;
        default: base = 8'($urandom);
      endcase
      write_tile_base(base);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_command();
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("wall_bitmap_autotiler_tb: PASS");
    end else begin
      $display("wall_bitmap_autotiler_tb: FAIL");
    end
    $finish;
  end

endmodule
